### src/bkf_pkg.sv
// ----------------------------------------------------------------------------
// bkf_pkg: shared types, constants and functions
// Widths, codes and the Q16.16 lerp / divide-by-three helpers.
// ----------------------------------------------------------------------------
package bkf_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam int IN_W       = 32;          // keyframe and result value width
    localparam int PT_W       = 36;          // control point / lerp width
    localparam int DIFF_W     = PT_W + 1;    // lerp difference width
    localparam int T_W        = 17;          // t in Q1.16, up to 1.0
    localparam int T_STEP_W   = 16;
    localparam int K_W        = 6;
    localparam int FRAC_BITS  = 16;
    localparam int MAG_W      = 35;          // divider magnitude width
    localparam int DIV_CHUNK  = 7;           // quotient bits per divider stage
    localparam int DIV_STAGES = MAG_W / DIV_CHUNK;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_BITS);

    localparam logic [1:0] KIND_FIRST = 2'd1;
    localparam logic [1:0] KIND_LAST  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_N_BETWEEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_T_STEP    = 1'b1;

    localparam logic [K_W-1:0]      N_BETWEEN_RST = 6'd3;
    localparam logic [T_STEP_W-1:0] T_STEP_RST    = 16'd16384;

    typedef logic signed [PT_W-1:0] pt_t;

    typedef struct packed {
        pt_t p1;
        pt_t a1;
        pt_t b2;
        pt_t p2;
    } seg_t;

    typedef struct packed {
        pt_t            p1;
        pt_t            a1;
        pt_t            b2;
        pt_t            p2;
        logic [T_W-1:0] t;
        logic [K_W-1:0] k;
        logic           last;
    } task_t;

    // a + floor((b - a) * t / 2^16)
    function automatic pt_t lerp_q16(input pt_t a, input pt_t b, input logic [T_W-1:0] t);
        logic signed [DIFF_W-1:0]    diff;
        logic signed [DIFF_W+T_W:0]  prod;
        logic signed [DIFF_W+T_W:0]  sh;
        diff = {b[PT_W-1], b} - {a[PT_W-1], a};
        prod = diff * $signed({1'b0, t});
        sh   = prod >>> FRAC_BITS;
        return a + $signed(sh[PT_W-1:0]);
    endfunction

    // Long division by three over one chunk: {remainder, quotient bits}
    function automatic logic [DIV_CHUNK+1:0] div3_chunk(input logic [1:0] rem,
                                                        input logic [DIV_CHUNK-1:0] bits);
        logic [2:0]           r;
        logic [DIV_CHUNK-1:0] q;
        r = {1'b0, rem};
        q = '0;
        for (int i = DIV_CHUNK - 1; i >= 0; i--)
        begin
            r = {r[1:0], bits[i]};
            if (r >= 3'd3)
            begin
                r    = r - 3'd3;
                q[i] = 1'b1;
            end
        end
        return {r[1:0], q};
    endfunction

endpackage

### src/bkf_ctrl_pts.sv
// ----------------------------------------------------------------------------
// bkf_ctrl_pts: inner control point pipeline
// Forms the a1/b2 numerators, divides by 3 or 6 in chunked stages, adds.
// ----------------------------------------------------------------------------
module bkf_ctrl_pts
    import bkf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [IN_W-1:0] p0,
    input  logic signed [IN_W-1:0] p1,
    input  logic signed [IN_W-1:0] p2,
    input  logic signed [IN_W-1:0] p3,
    input  logic [1:0]             kind,
    output logic                   out_valid,
    input  logic                   out_ready,
    output seg_t                   out_seg
);

    localparam int NST = DIV_STAGES + 2;

    typedef struct packed {
        logic signed [IN_W-1:0] p1;
        logic signed [IN_W-1:0] p2;
        logic [MAG_W-1:0]       ma;
        logic [MAG_W-1:0]       mb;
        logic [MAG_W-1:0]       qa;
        logic [MAG_W-1:0]       qb;
        logic [1:0]             ra;
        logic [1:0]             rb;
        logic                   na;
        logic                   nb;
        logic                   a6;
        logic                   b6;
    } front_t;

    logic   vld_reg [NST];
    logic   vin     [NST];
    logic   rdy     [NST];
    front_t st_reg  [DIV_STAGES+1];
    front_t st_next [DIV_STAGES+1];
    seg_t   seg_reg;
    seg_t   seg_next;

    assign vin[0] = in_valid;
    for (genvar s = 1; s < NST; s++)
    begin : g_vin
        assign vin[s] = vld_reg[s-1];
    end

    always_comb
    begin
        rdy[NST-1] = !vld_reg[NST-1] || out_ready;
        for (int s = NST - 2; s >= 0; s--)
        begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    // stage 0: numerators and magnitudes
    always_comb
    begin
        logic signed [MAG_W-1:0] e0, e1, e2, e3, da, db;
        logic                    first, last;
        e0    = MAG_W'(p0);
        e1    = MAG_W'(p1);
        e2    = MAG_W'(p2);
        e3    = MAG_W'(p3);
        first = (kind == KIND_FIRST);
        last  = (kind == KIND_LAST);
        da    = first ? (e2 <<< 1) - e3 - e1 : e2 - e0;
        db    = last  ? (e1 <<< 1) - e0 - e2 : e1 - e3;
        st_next[0].p1 = p1;
        st_next[0].p2 = p2;
        st_next[0].ma = da[MAG_W-1] ? MAG_W'(-da) : MAG_W'(da);
        st_next[0].mb = db[MAG_W-1] ? MAG_W'(-db) : MAG_W'(db);
        st_next[0].qa = '0;
        st_next[0].qb = '0;
        st_next[0].ra = 2'd0;
        st_next[0].rb = 2'd0;
        st_next[0].na = da[MAG_W-1];
        st_next[0].nb = db[MAG_W-1];
        st_next[0].a6 = !first;
        st_next[0].b6 = !last;
    end

    // stages 1..DIV_STAGES: one quotient chunk each, MSB first
    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_div
        localparam int HI = MAG_W - 1 - (s - 1) * DIV_CHUNK;
        always_comb
        begin
            logic [DIV_CHUNK+1:0] ca, cb;
            ca = div3_chunk(st_reg[s-1].ra, st_reg[s-1].ma[HI -: DIV_CHUNK]);
            cb = div3_chunk(st_reg[s-1].rb, st_reg[s-1].mb[HI -: DIV_CHUNK]);
            st_next[s]                       = st_reg[s-1];
            st_next[s].qa[HI -: DIV_CHUNK]   = ca[DIV_CHUNK-1:0];
            st_next[s].qb[HI -: DIV_CHUNK]   = cb[DIV_CHUNK-1:0];
            st_next[s].ra                    = ca[DIV_CHUNK+1:DIV_CHUNK];
            st_next[s].rb                    = cb[DIV_CHUNK+1:DIV_CHUNK];
        end
    end

    // final stage: halve for /6, restore sign, add to anchor
    always_comb
    begin
        front_t           f;
        logic [MAG_W-1:0] qa, qb;
        pt_t              sa, sb;
        f  = st_reg[DIV_STAGES];
        qa = f.a6 ? (f.qa >> 1) : f.qa;
        qb = f.b6 ? (f.qb >> 1) : f.qb;
        sa = f.na ? -pt_t'({1'b0, qa}) : pt_t'({1'b0, qa});
        sb = f.nb ? -pt_t'({1'b0, qb}) : pt_t'({1'b0, qb});
        seg_next.p1 = PT_W'(f.p1);
        seg_next.p2 = PT_W'(f.p2);
        seg_next.a1 = PT_W'(f.p1) + sa;
        seg_next.b2 = PT_W'(f.p2) + sb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            for (int s = 0; s < NST; s++)
            begin
                if (rdy[s])
                begin
                    vld_reg[s] <= vin[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= DIV_STAGES; s++)
        begin
            if (rdy[s] && vin[s])
            begin
                st_reg[s] <= st_next[s];
            end
        end
        if (rdy[NST-1] && vin[NST-1])
        begin
            seg_reg <= seg_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];
    assign out_seg   = seg_reg;

endmodule

### src/bkf_sampler.sv
// ----------------------------------------------------------------------------
// bkf_sampler: per-segment sample sequencer
// Holds one segment and issues k = 1..n_between with t = min(k*t_step, 1.0).
// ----------------------------------------------------------------------------
module bkf_sampler
    import bkf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [K_W-1:0]      n_between,
    input  logic [T_STEP_W-1:0] t_step,
    input  logic                seg_valid,
    output logic                seg_ready,
    input  seg_t                seg,
    output logic                task_valid,
    input  logic                task_ready,
    output task_t               task_data
);

    logic           busy_reg, busy_next;
    logic [K_W-1:0] k_reg, k_next;
    logic [T_W-1:0] t_reg, t_next;
    seg_t           seg_reg;
    logic           last;
    logic           fire;
    logic           done;
    logic           load;
    logic [T_W:0]   t_sum;

    assign last      = (k_reg == n_between);
    assign fire      = busy_reg && task_ready;
    assign done      = fire && last;
    assign seg_ready = !busy_reg || done;
    assign load      = seg_valid && seg_ready;
    assign t_sum     = {1'b0, t_reg} + (T_W+1)'(t_step);

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        t_next    = t_reg;
        if (load)
        begin
            busy_next = (n_between != '0);
            k_next    = K_W'(1);
            t_next    = T_W'(t_step);
        end
        else if (fire)
        begin
            if (done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                k_next = k_reg + K_W'(1);
                t_next = (t_sum > {1'b0, T_ONE}) ? T_ONE : t_sum[T_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= K_W'(1);
            t_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
            t_reg    <= t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seg_reg <= seg;
        end
    end

    assign task_valid     = busy_reg;
    assign task_data.p1   = seg_reg.p1;
    assign task_data.a1   = seg_reg.a1;
    assign task_data.b2   = seg_reg.b2;
    assign task_data.p2   = seg_reg.p2;
    assign task_data.t    = t_reg;
    assign task_data.k    = k_reg;
    assign task_data.last = last;

endmodule

### src/bkf_casteljau.sv
// ----------------------------------------------------------------------------
// bkf_casteljau: de Casteljau evaluation pipeline
// Three lerp levels, one per stage, then saturation into the output register.
// ----------------------------------------------------------------------------
module bkf_casteljau
    import bkf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            task_valid,
    output logic            task_ready,
    input  task_t           task_data,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [IN_W-1:0] m_tdata,
    output logic [K_W-1:0]  m_tuser,
    output logic            m_tlast
);

    localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

    typedef struct packed {
        pt_t            q0;
        pt_t            q1;
        pt_t            q2;
        logic [T_W-1:0] t;
        logic [K_W-1:0] k;
        logic           last;
    } l1_t;

    typedef struct packed {
        pt_t            r0;
        pt_t            r1;
        logic [T_W-1:0] t;
        logic [K_W-1:0] k;
        logic           last;
    } l2_t;

    typedef struct packed {
        pt_t            v;
        logic [K_W-1:0] k;
        logic           last;
    } l3_t;

    logic            v1_reg, v2_reg, v3_reg, vo_reg;
    logic            rdy1, rdy2, rdy3, rdyo;
    l1_t             l1_reg, l1_next;
    l2_t             l2_reg, l2_next;
    l3_t             l3_reg, l3_next;
    logic [IN_W-1:0] value_reg, value_next;
    logic [K_W-1:0]  k_reg;
    logic            last_reg;
    logic signed [63:0] vx;

    assign rdyo = !vo_reg || m_tready;
    assign rdy3 = !v3_reg || rdyo;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    always_comb
    begin
        l1_next.q0   = lerp_q16(task_data.p1, task_data.a1, task_data.t);
        l1_next.q1   = lerp_q16(task_data.a1, task_data.b2, task_data.t);
        l1_next.q2   = lerp_q16(task_data.b2, task_data.p2, task_data.t);
        l1_next.t    = task_data.t;
        l1_next.k    = task_data.k;
        l1_next.last = task_data.last;

        l2_next.r0   = lerp_q16(l1_reg.q0, l1_reg.q1, l1_reg.t);
        l2_next.r1   = lerp_q16(l1_reg.q1, l1_reg.q2, l1_reg.t);
        l2_next.t    = l1_reg.t;
        l2_next.k    = l1_reg.k;
        l2_next.last = l1_reg.last;

        l3_next.v    = lerp_q16(l2_reg.r0, l2_reg.r1, l2_reg.t);
        l3_next.k    = l2_reg.k;
        l3_next.last = l2_reg.last;

        vx = 64'(l3_reg.v);
        if (vx > VMAX)
        begin
            value_next = VMAX[IN_W-1:0];
        end
        else if (vx < VMIN)
        begin
            value_next = VMIN[IN_W-1:0];
        end
        else
        begin
            value_next = vx[IN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= task_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdyo)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && task_valid)
        begin
            l1_reg <= l1_next;
        end
        if (rdy2 && v1_reg)
        begin
            l2_reg <= l2_next;
        end
        if (rdy3 && v2_reg)
        begin
            l3_reg <= l3_next;
        end
        if (rdyo && v3_reg)
        begin
            value_reg <= value_next;
            k_reg     <= l3_reg.k;
            last_reg  <= l3_reg.last;
        end
    end

    assign task_ready = rdy1;
    assign m_tvalid   = vo_reg;
    assign m_tdata    = value_reg;
    assign m_tuser    = k_reg;
    assign m_tlast    = last_reg;

endmodule

### src/bezier_keyframe_interpolator.sv
// ----------------------------------------------------------------------------
// bezier_keyframe_interpolator: cubic Bezier keyframe in-betweening
// One keyframe window in, n_between de Casteljau samples out (Q16.16).
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                       | marks
//  ---------+-----+-----------------------------------------------+---------------
//  s_axis   | in  | tdata: prev, start, end, next (32 b each)     | tuser: kind
//  m_axis   | out | tdata: value (32 b, saturated)                | tuser: k, tlast
//  cfg      | in  | index 0 n_between, index 1 t_step             | ready always
//
//  The sampler issues one sample per cycle into the evaluation pipeline while it
//  accepts them, so it sets the rate at which keyframe windows are taken.
//  From input transfer to first sample the path holds 7 stages of
//  control point maths and divide, 1 sampler, 4 evaluation and output.
//  Reset clears all valid bits and loads n_between = 3, t_step = 16384.
//  Every stage holds under back-pressure; empty stages still fill, so input
//  transfers keep going while a finished sample waits on m_tready.
//
module bezier_keyframe_interpolator
    import bkf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [4*IN_W-1:0]     s_tdata,    // prev_value, start_value, end_value, next_value
    input  logic [1:0]            s_tuser,    // segment_kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [IN_W-1:0]       m_tdata,    // value
    output logic [K_W-1:0]        m_tuser,    // frame_offset
    output logic                  m_tlast,    // last_in_run
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [K_W-1:0]      n_between_reg;
    logic [T_STEP_W-1:0] t_step_reg;

    logic  seg_valid, seg_ready;
    seg_t  seg;
    logic  task_valid, task_ready;
    task_t task_data;

    // configuration: always ready; to be written only while idle, which the block itself does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_between_reg <= N_BETWEEN_RST;
            t_step_reg    <= T_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_N_BETWEEN: n_between_reg <= cfg_data[K_W-1:0];
                CFG_T_STEP:    t_step_reg    <= cfg_data[T_STEP_W-1:0];
                default:       ;
            endcase
        end
    end

    // control points a1, b2
    bkf_ctrl_pts u_ctrl_pts
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .p0        (s_tdata[IN_W-1:0]),
        .p1        (s_tdata[2*IN_W-1:IN_W]),
        .p2        (s_tdata[3*IN_W-1:2*IN_W]),
        .p3        (s_tdata[4*IN_W-1:3*IN_W]),
        .kind      (s_tuser),
        .out_valid (seg_valid),
        .out_ready (seg_ready),
        .out_seg   (seg)
    );

    // one sample per cycle per segment while the evaluation pipeline accepts
    bkf_sampler u_sampler
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .n_between  (n_between_reg),
        .t_step     (t_step_reg),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .seg        (seg),
        .task_valid (task_valid),
        .task_ready (task_ready),
        .task_data  (task_data)
    );

    // curve evaluation and saturation
    bkf_casteljau #(
        .VALUE_BITS (VALUE_BITS)
    ) u_casteljau
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (task_valid),
        .task_ready (task_ready),
        .task_data  (task_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

### src/bkf_checker.sv
// ----------------------------------------------------------------------------
// bkf_port_assert: port-level checks on the result stream
// Sample numbering, end-of-run marking and output hold under stall.
// ----------------------------------------------------------------------------
module bkf_port_assert
    import bkf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [IN_W-1:0]       m_tdata,
    input logic [K_W-1:0]        m_tuser,
    input logic                  m_tlast
);

    logic [K_W-1:0] exp_k_reg;
    logic [K_W-1:0] n_chk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_k_reg <= K_W'(1);
            n_chk_reg <= N_BETWEEN_RST;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                exp_k_reg <= m_tlast ? K_W'(1) : exp_k_reg + K_W'(1);
            end
            if (cfg_valid && cfg_ready && (cfg_index == CFG_N_BETWEEN))
            begin
                n_chk_reg <= cfg_data[K_W-1:0];
            end
        end
    end

    a_k_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != '0))
        else $error("frame offset zero");

    a_k_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == exp_k_reg))
        else $error("frame offset out of sequence");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == n_chk_reg)))
        else $error("tlast does not match sample count");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result changed while stalled");

endmodule

bind bezier_keyframe_interpolator bkf_port_assert u_bkf_port_assert
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);

### tb/bkf_checker.sv
// ----------------------------------------------------------------------------
// bkf_checker: scoreboard for the Bezier keyframe interpolator
// Watches the config, keyframe and sample channels, predicts every sample of
// each accepted window and compares it with what the block emits.
// ----------------------------------------------------------------------------
module bkf_checker
    import bkf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [4*IN_W-1:0]     s_tdata,    // prev_value, start_value, end_value, next_value
    input  logic [1:0]            s_tuser,    // segment_kind
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [IN_W-1:0]       m_tdata,    // value
    input  logic [K_W-1:0]        m_tuser,    // frame_offset
    input  logic                  m_tlast,    // last_in_run
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    frames_pending,
    output int                    mismatch_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [IN_W-1:0] value;
        logic [K_W-1:0]  frame;
        logic            last;
    } frame_t;

    frame_t               frames_due[$];
    logic [K_W-1:0]       n_frames;
    logic [T_STEP_W-1:0]  t_inc;
    int                   errors = 0;

    // a + floor((b - a) * t / 2^16); >>> on a signed longint floors
    function automatic longint lerp_floor(input longint a, input longint b, input longint t);
        return a + (((b - a) * t) >>> FRAC_BITS);
    endfunction

    function automatic logic [IN_W-1:0] curve_value(input longint p1, input longint a1,
                                                    input longint b2, input longint p2,
                                                    input longint t);
        longint q0, q1, q2, r0, r1, v;
        longint vmax, vmin;
        vmax = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
        vmin = -vmax - 1;
        q0 = lerp_floor(p1, a1, t);
        q1 = lerp_floor(a1, b2, t);
        q2 = lerp_floor(b2, p2, t);
        r0 = lerp_floor(q0, q1, t);
        r1 = lerp_floor(q1, q2, t);
        v  = lerp_floor(r0, r1, t);
        if (v > vmax)
            v = vmax;
        if (v < vmin)
            v = vmin;
        return v[IN_W-1:0];
    endfunction

    task automatic queue_frames(input logic [4*IN_W-1:0] win, input logic [1:0] kind);
        longint p0, p1, p2, p3, a1, b2, tu;
        frame_t f;
        p0 = longint'($signed(win[0*IN_W +: IN_W]));
        p1 = longint'($signed(win[1*IN_W +: IN_W]));
        p2 = longint'($signed(win[2*IN_W +: IN_W]));
        p3 = longint'($signed(win[3*IN_W +: IN_W]));
        // divisions truncate toward zero, as integer division does here
        if (kind == KIND_FIRST)
        begin
            a1 = p1 + (2 * p2 - p3 - p1) / 3;
            b2 = p2 - (p3 - p1) / 6;
        end
        else if (kind == KIND_LAST)
        begin
            a1 = p1 + (p2 - p0) / 6;
            b2 = p2 + (2 * p1 - p0 - p2) / 3;
        end
        else
        begin
            a1 = p1 + (p2 - p0) / 6;
            b2 = p2 - (p3 - p1) / 6;
        end
        for (int k = 1; k <= n_frames; k++)
        begin
            tu = longint'(k) * longint'(t_inc);
            if (tu > longint'(T_ONE))
                tu = longint'(T_ONE);
            f.value = curve_value(p1, a1, b2, p2, tu);
            f.frame = K_W'(k);
            f.last  = (k == n_frames);
            frames_due.push_back(f);
        end
    endtask

    task automatic check_frame();
        frame_t f;
        if (frames_due.size() == 0)
        begin
            if (errors < 10)
                $display("%0t: unexpected frame: value %h k %0d last %b",
                         $time, m_tdata, m_tuser, m_tlast);
            errors++;
        end
        else
        begin
            f = frames_due.pop_front();
            if (m_tdata !== f.value || m_tuser !== f.frame || m_tlast !== f.last)
            begin
                if (errors < 10)
                    $display("%0t: frame mismatch: expected value %h k %0d last %b, got value %h k %0d last %b",
                             $time, f.value, f.frame, f.last, m_tdata, m_tuser, m_tlast);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_frames = N_BETWEEN_RST;
            t_inc    = T_STEP_RST;
            frames_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_frame();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_N_BETWEEN)
                    n_frames = cfg_data[K_W-1:0];
                else if (cfg_index == CFG_T_STEP)
                    t_inc = cfg_data[T_STEP_W-1:0];
            end
            if (s_tvalid && s_tready)
                queue_frames(s_tdata, s_tuser);
        end
        frames_pending <= frames_due.size();
        mismatch_count <= errors;
    end

endmodule

### tb/tb_bezier_keyframe_interpolator.sv
// ----------------------------------------------------------------------------
// tb_bezier_keyframe_interpolator: testbench top
// Drives keyframe windows and sampling settings into the interpolator, with
// random back-pressure on the sample side; bkf_checker does the scoring.
// ----------------------------------------------------------------------------
module tb_bezier_keyframe_interpolator;

    import bkf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // segment kinds the package leaves unnamed
    localparam logic [1:0] KIND_MIDDLE   = 2'd0;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    localparam logic [IN_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [IN_W-1:0] VAL_MIN = 32'h8000_0000;

    // drain wait that covers windows still in flight that emit nothing
    localparam int DRAIN_CYCLES   = 24;
    // cycles with no transfer on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 3000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [4*IN_W-1:0]     s_tdata;    // prev_value, start_value, end_value, next_value
    logic [1:0]            s_tuser;    // segment_kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [IN_W-1:0]       m_tdata;    // value
    logic [K_W-1:0]        m_tuser;    // frame_offset
    logic                  m_tlast;    // last_in_run
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int frames_pending;
    int mismatch_count;

    // idle percentages for the keyframe sender and the frame receiver
    int send_idle_pct = 36;
    int recv_idle_pct = 69;
    int quiet_cycles  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bezier_keyframe_interpolator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bkf_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .frames_pending (frames_pending),
        .mismatch_count (mismatch_count)
    );

    // receiver: ready is redrawn every cycle, so stalls land on any phase
    always @(negedge clk)
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);

    // watchdog: any transfer on any channel restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // All tasks below start and end on a falling edge. Valid is left high
    // after a transfer, so back-to-back items never drop it for a step.
    task automatic send_window(input logic [IN_W-1:0] p0, input logic [IN_W-1:0] p1,
                               input logic [IN_W-1:0] p2, input logic [IN_W-1:0] p3,
                               input logic [1:0] kind);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {p3, p2, p1, p0};
        s_tuser  = kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // As many smooth windows (neighbouring keys close together) as full-range
    // noise ones, the rest rail, zero or random values.
    task automatic send_random_window();
        logic [IN_W-1:0] v[4];
        logic [IN_W-1:0] base;
        int              mode;
        int              pick;
        logic [1:0]      kind;
        mode = $urandom_range(0, 9);
        base = $urandom;
        for (int i = 0; i < 4; i++)
        begin
            if (mode < 4)
            begin
                v[i] = base;
                base = base + $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
            end
            else if (mode < 8)
                v[i] = $urandom;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       v[i] = VAL_MAX;
                    1:       v[i] = VAL_MIN;
                    2:       v[i] = '0;
                    default: v[i] = $urandom;
                endcase
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 4)
            kind = KIND_MIDDLE;
        else if (pick < 6)
            kind = KIND_FIRST;
        else if (pick < 9)
            kind = KIND_LAST;
        else
            kind = KIND_RESERVED;
        send_window(v[0], v[1], v[2], v[3], kind);
    endtask

    task automatic run_random(input int count);
        repeat (count)
            send_random_window();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Registers only change with the block empty: every frame back, then a
    // pause for windows still in flight that emit nothing.
    task automatic set_sampling(input int n, input int step);
        s_tvalid = 1'b0;
        while (frames_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        write_reg(CFG_N_BETWEEN, CFG_DATA_W'(n));
        write_reg(CFG_T_STEP, CFG_DATA_W'(step));
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int n;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_MIDDLE;
        cfg_valid = 1'b0;
        cfg_index = CFG_N_BETWEEN;
        cfg_data  = '0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed: reset sampling (3 frames, quarter steps) ----
        send_window('0, '0, '0, '0, KIND_MIDDLE);
        send_window(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, KIND_FIRST);
        send_window(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, KIND_LAST);
        // tangents overshoot the rails: saturation both ways
        send_window(VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, KIND_MIDDLE);
        send_window(VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX, KIND_MIDDLE);
        send_window(VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, KIND_FIRST);
        send_window(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, KIND_LAST);
        // reserved kind behaves as a middle segment
        send_window(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, KIND_RESERVED);
        send_window(32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0008_0000, KIND_RESERVED);
        // small negatives: truncating divide against flooring shift
        send_window(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, KIND_FIRST);

        // zero frame count: windows are taken but nothing comes out
        set_sampling(0, 16384);
        run_random(2);
        // zero step: every frame sits on the start key
        set_sampling(5, 0);
        run_random(2);
        // step overruns 1.0 from the second frame on
        set_sampling(4, 65535);
        send_window(VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, KIND_MIDDLE);
        run_random(1);
        // longest run and the shortest one
        set_sampling(63, 1024);
        run_random(1);
        set_sampling(1, 32768);
        run_random(2);

        // ---- random, sender 36 % idle, receiver 69 % ----
        set_sampling(3, 16384);
        run_random(70);

        // ---- random, sender 69 % idle, receiver 36 % ----
        send_idle_pct = 69;
        recv_idle_pct = 36;
        set_sampling(1, 32768);
        run_random(35);
        set_sampling(63, 1);
        run_random(10);
        repeat (5)
        begin
            n = $urandom_range(1, 63);
            set_sampling(n, 65536 / (n + 1));
            run_random(5);
        end

        // ---- random, no idling on either side ----
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_sampling(7, 8192);
        run_random(40);
        repeat (5)
        begin
            set_sampling($urandom_range(1, 63), $urandom_range(0, 65535));
            run_random(6);
        end

        // ---- drain and verdict ----
        s_tvalid = 1'b0;
        while (frames_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (mismatch_count == 0 && frames_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
